@@ sv/layered_alpha_pixel_compositor_defines.svh @@
// Assertion macros for the layered alpha pixel compositor.
`ifndef LAYERED_ALPHA_PIXEL_COMPOSITOR_DEFINES_SVH
`define LAYERED_ALPHA_PIXEL_COMPOSITOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LAPC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LAPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/lapc_pkg.sv @@
// Package: constants, codes and stage types of the layered alpha compositor.
`timescale 1ns / 1ps
package lapc_pkg;

  localparam int PIX_W   = 32;
  localparam int CH_W    = 8;
  localparam int RGB_W   = 24;
  localparam int SUM_W   = 16;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CH_W-1:0] ALPHA_MAX = 8'hFF;

  localparam logic [MODE_W-1:0] MODE_OVER  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MARK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LAYER = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYER = 1'b1;

  typedef struct packed {
    logic [RGB_W-1:0] base;
    logic [RGB_W-1:0] top;
    logic [CH_W-1:0]  wgt;
    logic [CH_W-1:0]  alpha;
    logic             pix_wr;
    logic             depth_wr;
    logic [CH_W-1:0]  new_depth;
    logic [PIX_W-1:0] dst;
  } dec_t;

  typedef struct packed {
    logic [2:0][SUM_W-1:0] sum;
    logic [CH_W-1:0]       alpha;
    logic                  pix_wr;
    logic                  depth_wr;
    logic [CH_W-1:0]       new_depth;
    logic [PIX_W-1:0]      dst;
  } mul_t;

  typedef struct packed {
    logic [PIX_W-1:0] new_pixel;
    logic             pixel_write;
    logic             depth_write;
    logic [CH_W-1:0]  new_depth;
  } res_t;

endpackage

@@ sv/lapc_if.sv @@
// Request channel interfaces for pixel input and composited result.
`timescale 1ns / 1ps
interface lapc_in_if;
  logic                        valid;
  logic                        ready;
  logic [lapc_pkg::PIX_W-1:0]  source_pixel;
  logic [lapc_pkg::PIX_W-1:0]  dest_pixel;
  logic [lapc_pkg::CH_W-1:0]   depth_value;

  modport source (output valid, output source_pixel, output dest_pixel,
                  output depth_value, input ready);
  modport sink   (input valid, input source_pixel, input dest_pixel,
                  input depth_value, output ready);
endinterface

interface lapc_out_if;
  logic                        valid;
  logic                        ready;
  logic [lapc_pkg::PIX_W-1:0]  new_pixel;
  logic                        pixel_write;
  logic                        depth_write;
  logic [lapc_pkg::CH_W-1:0]   new_depth;

  modport source (output valid, output new_pixel, output pixel_write,
                  output depth_write, output new_depth, input ready);
  modport sink   (input valid, input new_pixel, input pixel_write,
                  input depth_write, input new_depth, output ready);
endinterface

@@ sv/lapc_decode.sv @@
// Stage 1: mode decode, operand and weight selection, write flags.
`timescale 1ns / 1ps
module lapc_decode (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lapc_pkg::MODE_W-1:0] mode,
  input  logic [lapc_pkg::CH_W-1:0]   layer,
  input  logic                        in_valid,
  input  logic [lapc_pkg::PIX_W-1:0]  source_pixel,
  input  logic [lapc_pkg::PIX_W-1:0]  dest_pixel,
  input  logic [lapc_pkg::CH_W-1:0]   depth_value,
  input  logic                        down_take,
  output logic                        take,
  output logic                        dec_valid,
  output lapc_pkg::dec_t              dec
);
  import lapc_pkg::*;

  logic            valid_r;
  dec_t            dec_r;
  dec_t            dec_nxt;
  logic [CH_W-1:0] src_a;
  logic [CH_W-1:0] dst_a;

  assign src_a = source_pixel[PIX_W-1 -: CH_W];
  assign dst_a = dest_pixel[PIX_W-1 -: CH_W];
  assign take  = !valid_r || down_take;

  always_comb begin
    dec_nxt           = '0;
    dec_nxt.base      = dest_pixel[RGB_W-1:0];
    dec_nxt.top       = source_pixel[RGB_W-1:0];
    dec_nxt.wgt       = src_a;
    dec_nxt.alpha     = ALPHA_MAX;
    dec_nxt.dst       = dest_pixel;
    unique case (mode)
      MODE_OVER: begin
        dec_nxt.pix_wr = (src_a != '0);
      end
      MODE_MARK: begin
        if (src_a != '0) begin
          dec_nxt.depth_wr  = 1'b1;
          dec_nxt.new_depth = layer;
        end
      end
      MODE_LAYER: begin
        if (depth_value >= layer) begin
          dec_nxt.pix_wr = (src_a != '0);
          dec_nxt.alpha  = src_a;
        end else if (dst_a != ALPHA_MAX) begin
          // rear branch: source under destination, weighted by dest alpha
          dec_nxt.pix_wr = 1'b1;
          dec_nxt.base   = source_pixel[RGB_W-1:0];
          dec_nxt.top    = dest_pixel[RGB_W-1:0];
          dec_nxt.wgt    = dst_a;
          dec_nxt.alpha  = dst_a;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      dec_r <= dec_nxt;
    end
  end

  assign dec_valid = valid_r;
  assign dec       = dec_r;
endmodule

@@ sv/lapc_mul.sv @@
// Stage 2: weighted channel products base*(255-a) + top*a.
`timescale 1ns / 1ps
module lapc_mul (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           dec_valid,
  input  lapc_pkg::dec_t dec,
  input  logic           down_take,
  output logic           take,
  output logic           mul_valid,
  output lapc_pkg::mul_t mul
);
  import lapc_pkg::*;

  logic            valid_r;
  mul_t            mul_r;
  mul_t            mul_nxt;
  logic [CH_W-1:0] inv;

  assign inv  = ALPHA_MAX - dec.wgt;
  assign take = !valid_r || down_take;

  always_comb begin
    logic [SUM_W-1:0] pb;
    logic [SUM_W-1:0] pt;
    logic [SUM_W:0]   s;
    mul_nxt           = '0;
    mul_nxt.alpha     = dec.alpha;
    mul_nxt.pix_wr    = dec.pix_wr;
    mul_nxt.depth_wr  = dec.depth_wr;
    mul_nxt.new_depth = dec.new_depth;
    mul_nxt.dst       = dec.dst;
    for (int c = 0; c < 3; c++) begin
      pb = {{(SUM_W-CH_W){1'b0}}, dec.base[c*CH_W +: CH_W]} *
           {{(SUM_W-CH_W){1'b0}}, inv};
      pt = {{(SUM_W-CH_W){1'b0}}, dec.top[c*CH_W +: CH_W]} *
           {{(SUM_W-CH_W){1'b0}}, dec.wgt};
      // weights add to 255, so the sum never exceeds 255*255
      s  = {1'b0, pb} + {1'b0, pt};
      mul_nxt.sum[c] = s[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && dec_valid) begin
      mul_r <= mul_nxt;
    end
  end

  assign mul_valid = valid_r;
  assign mul       = mul_r;
endmodule

@@ sv/lapc_div.sv @@
// Stage 3: divide by 255, pixel assembly and output register.
`timescale 1ns / 1ps
module lapc_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           mul_valid,
  input  lapc_pkg::mul_t mul,
  input  logic           out_ready,
  output logic           take,
  output logic           res_valid,
  output lapc_pkg::res_t res
);
  import lapc_pkg::*;

  logic valid_r;
  res_t res_r;
  res_t res_nxt;

  assign take = !valid_r || out_ready;

  always_comb begin
    logic [SUM_W:0]   t;
    logic [RGB_W-1:0] rgb;
    rgb = '0;
    for (int c = 0; c < 3; c++) begin
      // floor(x/255) = (x + 1 + (x >> 8)) >> 8, exact for x below 65535
      t = {1'b0, mul.sum[c]} + {{SUM_W{1'b0}}, 1'b1} +
          {{(CH_W+1){1'b0}}, mul.sum[c][SUM_W-1:CH_W]};
      rgb[c*CH_W +: CH_W] = t[2*CH_W-1:CH_W];
    end
    res_nxt.new_pixel   = mul.pix_wr ? {mul.alpha, rgb} : mul.dst;
    res_nxt.pixel_write = mul.pix_wr;
    res_nxt.depth_write = mul.depth_wr;
    res_nxt.new_depth   = mul.new_depth;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && mul_valid) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = valid_r;
  assign res       = res_r;
endmodule

@@ sv/layered_alpha_pixel_compositor.sv @@
// Layered alpha pixel compositor: config registers and three-stage pipeline.
//
// Usage: present source pixel, destination pixel and stored layer value on
// in_ch; a request is taken when valid and ready are both high. Each request
// yields exactly one result on out_ch: the new destination pixel, the pixel
// and layer-buffer write flags and the layer value to store.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 mode,
// 1 layer); write only while no request is in flight.
// Requests pass the decode, multiply and divide stages in order, each stage
// one register. Throughput: one request per cycle while out_ch is ready; the
// widest path is the 8x8 channel multipliers followed by the product add.
// Reset (synchronous, rst_n low) empties the pipeline and sets mode and
// layer to 0. When the receiver holds ready low, the result register holds;
// ready on in_ch stays high until every stage is full, so up to three
// requests are absorbed and nothing is dropped or repeated.
`timescale 1ns / 1ps
`include "layered_alpha_pixel_compositor_defines.svh"
module layered_alpha_pixel_compositor (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lapc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lapc_pkg::CFG_DATA_W-1:0] cfg_data,
  lapc_in_if.sink                         in_ch,
  lapc_out_if.source                      out_ch
);
  import lapc_pkg::*;

  logic [MODE_W-1:0] mode_r;
  logic [CH_W-1:0]   layer_r;

  logic take1, take2, take3;
  logic dec_valid, mul_valid, res_valid;
  dec_t dec;
  mul_t mul;
  res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_OVER;
      layer_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:  mode_r  <= cfg_data[MODE_W-1:0];
        CFG_LAYER: layer_r <= cfg_data[CH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lapc_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .mode         (mode_r),
    .layer        (layer_r),
    .in_valid     (in_ch.valid),
    .source_pixel (in_ch.source_pixel),
    .dest_pixel   (in_ch.dest_pixel),
    .depth_value  (in_ch.depth_value),
    .down_take    (take2),
    .take         (take1),
    .dec_valid    (dec_valid),
    .dec          (dec)
  );

  lapc_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec_valid (dec_valid),
    .dec       (dec),
    .down_take (take3),
    .take      (take2),
    .mul_valid (mul_valid),
    .mul       (mul)
  );

  lapc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .mul_valid (mul_valid),
    .mul       (mul),
    .out_ready (out_ch.ready),
    .take      (take3),
    .res_valid (res_valid),
    .res       (res)
  );

  assign in_ch.ready        = take1;
  assign out_ch.valid       = res_valid;
  assign out_ch.new_pixel   = res.new_pixel;
  assign out_ch.pixel_write = res.pixel_write;
  assign out_ch.depth_write = res.depth_write;
  assign out_ch.new_depth   = res.new_depth;

  `LAPC_ASSERT_SAME(a_flags_exclusive, clk, rst_n, out_ch.valid,
    !(out_ch.pixel_write && out_ch.depth_write), "pixel and depth write both set")
  `LAPC_ASSERT_SAME(a_depth_value, clk, rst_n, out_ch.valid && out_ch.depth_write,
    out_ch.new_depth == layer_r && mode_r == MODE_MARK, "depth write with wrong layer")
  `LAPC_ASSERT_SAME(a_full_backpressure, clk, rst_n,
    dec_valid && mul_valid && res_valid && !out_ch.ready,
    !in_ch.ready, "request taken while pipeline full and stalled")
  `LAPC_ASSERT_NEXT(a_drain_moves, clk, rst_n, mul_valid && take3,
    res_valid, "stage 2 item lost on advance")
endmodule

@@ tb/lapc_blend_checker.sv @@
// Checker: predicts every composited pixel and compares it with the block's result.
`timescale 1ns / 1ps
module lapc_blend_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lapc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lapc_pkg::CFG_DATA_W-1:0] cfg_data,
  lapc_in_if                              in_mon,
  lapc_out_if                             out_mon,
  output int                              fail_count,
  output int                              pending_results
);
  import lapc_pkg::*;

  localparam int MAX_PRINTED = 100;

  logic [MODE_W-1:0] mode_q;
  logic [CH_W-1:0]   layer_q;
  res_t              expected_pixels[$];

  // floor((base*(255-wgt) + top*wgt) / 255) for one colour byte
  function automatic logic [CH_W-1:0] mix_byte(input logic [CH_W-1:0] base,
                                               input logic [CH_W-1:0] top,
                                               input logic [CH_W-1:0] wgt);
    int unsigned acc;
    acc = int'(base) * (int'(ALPHA_MAX) - int'(wgt)) + int'(top) * int'(wgt);
    return CH_W'(acc / int'(ALPHA_MAX));
  endfunction

  function automatic logic [RGB_W-1:0] mix_rgb(input logic [PIX_W-1:0] base,
                                               input logic [PIX_W-1:0] top,
                                               input logic [CH_W-1:0]  wgt);
    return {mix_byte(base[23:16], top[23:16], wgt),
            mix_byte(base[15:8],  top[15:8],  wgt),
            mix_byte(base[7:0],   top[7:0],   wgt)};
  endfunction

  function automatic res_t composite_pixel(input logic [MODE_W-1:0] mode,
                                           input logic [CH_W-1:0]   layer,
                                           input logic [PIX_W-1:0]  src,
                                           input logic [PIX_W-1:0]  dst,
                                           input logic [CH_W-1:0]   depth);
    res_t            r;
    logic [CH_W-1:0] src_a;
    logic [CH_W-1:0] dst_a;
    src_a         = src[31:24];
    dst_a         = dst[31:24];
    r.new_pixel   = dst;
    r.pixel_write = 1'b0;
    r.depth_write = 1'b0;
    r.new_depth   = '0;
    case (mode)
      MODE_OVER: begin
        if (src_a != 0) begin
          r.new_pixel   = {ALPHA_MAX, mix_rgb(dst, src, src_a)};
          r.pixel_write = 1'b1;
        end
      end
      MODE_MARK: begin
        if (src_a != 0) begin
          r.depth_write = 1'b1;
          r.new_depth   = layer;
        end
      end
      MODE_LAYER: begin
        if (depth >= layer) begin
          if (src_a != 0) begin
            r.new_pixel   = {src_a, mix_rgb(dst, src, src_a)};
            r.pixel_write = 1'b1;
          end
        end else if (dst_a != ALPHA_MAX) begin
          // pixel lies behind the stored layer: slide it under the destination
          r.new_pixel   = {dst_a, mix_rgb(src, dst, dst_a)};
          r.pixel_write = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(input string field, input logic [PIX_W-1:0] got,
                        input logic [PIX_W-1:0] want);
    if (fail_count < MAX_PRINTED)
      $display("[%0t] mismatch %s: got %h, expected %h", $time, field, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      mode_q  = MODE_OVER;
      layer_q = '0;
      expected_pixels.delete();
      pending_results = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MODE) mode_q = cfg_data[MODE_W-1:0];
        else if (cfg_index == CFG_LAYER) layer_q = cfg_data;
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_pixels.push_back(composite_pixel(mode_q, layer_q, in_mon.source_pixel,
                                                  in_mon.dest_pixel, in_mon.depth_value));
        pending_results++;
      end
      if (out_mon.valid && out_mon.ready) begin
        got.new_pixel   = out_mon.new_pixel;
        got.pixel_write = out_mon.pixel_write;
        got.depth_write = out_mon.depth_write;
        got.new_depth   = out_mon.new_depth;
        if (expected_pixels.size() == 0) begin
          report("unrequested result", got.new_pixel, '0);
        end else begin
          want = expected_pixels.pop_front();
          pending_results--;
          if (got.new_pixel !== want.new_pixel)
            report("new_pixel", got.new_pixel, want.new_pixel);
          if (got.pixel_write !== want.pixel_write)
            report("pixel_write", PIX_W'(got.pixel_write), PIX_W'(want.pixel_write));
          if (got.depth_write !== want.depth_write)
            report("depth_write", PIX_W'(got.depth_write), PIX_W'(want.depth_write));
          if (got.new_depth !== want.new_depth)
            report("new_depth", PIX_W'(got.new_depth), PIX_W'(want.new_depth));
        end
      end
    end
  end

endmodule

@@ tb/layered_alpha_pixel_compositor_tb.sv @@
// Testbench top: clock, reset, pixel requests, register writes and the verdict.
`timescale 1ns / 1ps
module layered_alpha_pixel_compositor_tb;
  import lapc_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int LIMIT_NS   = 4_000_000;
  localparam int PHASES     = 8;
  localparam int PHASE_ITEMS = 94;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending_results;

  bit                    tx_steady;
  bit                    rx_steady;
  int                    stall_left;
  logic [CH_W-1:0]       cur_layer;

  lapc_in_if  in_ch ();
  lapc_out_if out_ch ();

  layered_alpha_pixel_compositor DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  lapc_blend_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #LIMIT_NS;
    $display("status: fail");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random back-pressure unless the phase runs steady
  always begin
    @(negedge clk);
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (!rx_steady && $urandom_range(0, 2) == 0) stall_left = stall_len();
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] src, input logic [PIX_W-1:0] dst,
                            input logic [CH_W-1:0] depth);
    int gap;
    in_ch.valid        <= 1'b1;
    in_ch.source_pixel <= src;
    in_ch.dest_pixel   <= dst;
    in_ch.depth_value  <= depth;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    gap = tx_steady ? 0 : gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Hold off new requests until every result is back
  task automatic wait_results();
    in_ch.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == CFG_LAYER) cur_layer = data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic [MODE_W-1:0] mode, input logic [CH_W-1:0] layer);
    logic [CFG_DATA_W-1:0] mode_word;
    wait_results();
    // upper bits of the mode word are junk the register must drop
    mode_word = CFG_DATA_W'($urandom);
    mode_word[MODE_W-1:0] = mode;
    write_reg(CFG_MODE, mode_word);
    write_reg(CFG_LAYER, layer);
  endtask

  function automatic logic [CH_W-1:0] pick_alpha();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1:    return '0;
      2, 3:    return ALPHA_MAX;
      4:       return 8'd1;
      5:       return 8'd254;
      default: return CH_W'($urandom);
    endcase
  endfunction

  // Depth values cluster around the current layer to hit both sides of the compare
  function automatic logic [CH_W-1:0] pick_depth();
    int r;
    r = $urandom_range(0, 5);
    case (r)
      0:       return cur_layer;
      1:       return cur_layer - 8'd1;
      2:       return cur_layer + 8'd1;
      3:       return ($urandom_range(0, 1) != 0) ? ALPHA_MAX : 8'd0;
      default: return CH_W'($urandom);
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel(input logic [CH_W-1:0] alpha);
    return {alpha, RGB_W'($urandom)};
  endfunction

  initial begin
    logic [MODE_W-1:0] mode;
    logic [CH_W-1:0]   layer;
    int                r;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.source_pixel = '0;
    in_ch.dest_pixel   = '0;
    in_ch.depth_value  = '0;
    tx_steady          = 1'b0;
    rx_steady          = 1'b0;
    cur_layer          = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // plain over straight out of reset
    send_pixel(32'h00_112233, 32'h5A_C3A5_3C, 8'h00);
    send_pixel(32'hFF_FFFFFF, 32'h00_000000, 8'hFF);
    send_pixel(32'h01_FFFFFF, 32'hFF_000000, 8'h00);
    send_pixel(32'hFE_000000, 32'hFF_FFFFFF, 8'h80);
    send_pixel(32'h80_A55AC3, 32'h7F_3CC35A, 8'h01);

    configure(MODE_MARK, 8'hFF);
    send_pixel(32'h00_FFFFFF, 32'h12_345678, 8'h00);
    send_pixel(32'hFF_000000, 32'hFF_FFFFFF, 8'hFF);
    configure(MODE_MARK, 8'h00);
    send_pixel(32'h01_ABCDEF, 32'h00_000000, 8'h7F);

    configure(MODE_LAYER, 8'h00);
    send_pixel(32'h00_C0FFEE, 32'h44_556677, 8'h00);
    send_pixel(32'hFF_123456, 32'h00_FEDCBA, 8'hFF);
    send_pixel(32'h80_FFFFFF, 32'h80_000000, 8'h00);

    configure(MODE_LAYER, 8'hFF);
    send_pixel(32'h40_F0F0F0, 32'h20_0F0F0F, 8'hFF);
    send_pixel(32'hFF_FFFFFF, 32'hFF_000000, 8'hFE);
    send_pixel(32'hFF_FFFFFF, 32'h00_123456, 8'h00);
    send_pixel(32'h33_00FF80, 32'h9C_FF0080, 8'h07);

    configure(MODE_LAYER, 8'h80);
    send_pixel(32'hC0_112233, 32'h60_AABBCC, 8'h7F);
    send_pixel(32'h00_112233, 32'h60_AABBCC, 8'h80);
    send_pixel(32'h01_FFFFFF, 32'hFE_000000, 8'h81);

    configure(MODE_SPARE, 8'hFF);
    send_pixel(32'hFF_FFFFFF, 32'h00_000000, 8'h00);
    send_pixel(32'h00_000000, 32'hFF_FFFFFF, 8'hFF);

    for (int p = 0; p < PHASES; p++) begin
      r = $urandom_range(0, 9);
      if (r < 3) mode = MODE_OVER;
      else if (r < 5) mode = MODE_MARK;
      else if (r < 9) mode = MODE_LAYER;
      else mode = MODE_SPARE;
      r = $urandom_range(0, 3);
      if (r == 0) layer = '0;
      else if (r == 1) layer = ALPHA_MAX;
      else layer = CH_W'($urandom);
      configure(mode, layer);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == PHASE_ITEMS / 2) wait_results();
        send_pixel(rand_pixel(pick_alpha()), rand_pixel(pick_alpha()), pick_depth());
      end
    end

    wait_results();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/lapc_pkg.sv
sv/lapc_if.sv
sv/lapc_decode.sv
sv/lapc_mul.sv
sv/lapc_div.sv
sv/layered_alpha_pixel_compositor.sv
tb/lapc_blend_checker.sv
tb/layered_alpha_pixel_compositor_tb.sv
